// File: rtl/core/ps2dp_pkg.sv
package ps2dp_pkg;

  localparam int unsigned MaxPorts = 2;

  localparam logic [7:0] BYTE_ACK    = 8'hfa;
  localparam logic [7:0] BYTE_RESEND = 8'hfe;
  localparam logic [7:0] ID_KBD_LEAD = 8'hab;
  localparam logic [7:0] ID_MOUSE    = 8'h00;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [3:0]  RETRIES_RESET = 4'd3;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_IDENT  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RETRIES = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_UNCONF   = 3'd0,
    PH_ID_ACK   = 3'd1,
    PH_ID_0     = 3'd2,
    PH_ID_1     = 3'd3,
    PH_DATA_ACK = 3'd4,
    PH_DATA_0   = 3'd5
  } phase_e;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_RETRIES = 1'b1
  } cfg_idx_e;

  // flag bits
  localparam int unsigned FlAck    = 0;
  localparam int unsigned FlResend = 1;

  typedef struct packed {
    logic [1:0] mode;
    logic       port;
    logic [1:0] kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic       send_port;
    logic [7:0] send_byte;
    logic       done_res;
    logic [1:0] done_status;
    logic [1:0] id_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       device_class;
    logic       class_guessed;
    logic       unexpected_byte;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic       idx;
    logic [15:0] data;
  } cfg_wr_t;

  // request from the controller to one port tracker
  typedef struct packed {
    logic       absorb;
    logic       launch;
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } port_cmd_t;

  // port state as it stands after the received word has been applied
  typedef struct packed {
    phase_e     phase;
    logic [1:0] flags;
    logic [7:0] first;
    logic [7:0] second;
    logic       unexpected;
  } port_view_t;

endpackage

// File: rtl/core/ps2_device_probe_engine.sv
// ps2 host probe engine for up to two ports: takes start, received-byte and
// tick words and returns exactly one result word for each, carrying a byte to
// send, a completion status with any captured data or identify class, and an
// unexpected-byte flag. throughput is one word per clock while the output is
// taken; a word waits in the input register and moves into the result register
// once that register is empty or being read. configuration is written through
// its own port and must only be written while no command runs.
module ps2_device_probe_engine #(
  parameter int unsigned PORT_COUNT = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ps2dp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ps2dp_pkg::out_item_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import ps2dp_pkg::*;

  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q;
  logic       out_vld_q;
  logic       advance;
  out_item_t  res;
  cfg_wr_t    cfg;
  port_cmd_t  cmds  [MaxPorts];
  port_view_t views [MaxPorts];

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;
  assign cfg         = '{we: cfg_valid_i, idx: cfg_index_i, data: cfg_data_i};

  for (genvar p = 0; p < MaxPorts; p++) begin : g_port
    if (p < PORT_COUNT) begin : g_on
      ps2dp_port u_port (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmds[p]),
        .view_o (views[p])
      );
    end else begin : g_off
      assign views[p] = '0;
    end
  end

  ps2dp_ctrl #(
    .PORT_COUNT(PORT_COUNT)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (advance),
    .item_i  (in_q),
    .views_i (views),
    .cmds_o  (cmds),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/ps2dp_port.sv
module ps2dp_port (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2dp_pkg::port_cmd_t  cmd_i,
  output ps2dp_pkg::port_view_t view_o
);
  import ps2dp_pkg::*;

  phase_e     phase_q, phase_d, phase_abs;
  logic [1:0] flags_q, flags_d, flags_abs;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       unexp;

  // byte absorption
  always_comb begin
    phase_abs = phase_q;
    flags_abs = flags_q;
    first_d   = first_q;
    second_d  = second_q;
    unexp     = 1'b0;
    if (cmd_i.absorb) begin
      unique case (phase_q)
        PH_ID_0: begin
          first_d   = cmd_i.rx_byte;
          phase_abs = PH_ID_1;
        end
        PH_ID_1: begin
          second_d  = cmd_i.rx_byte;
          phase_abs = PH_UNCONF;
        end
        PH_DATA_0: begin
          first_d   = cmd_i.rx_byte;
          phase_abs = PH_UNCONF;
        end
        PH_UNCONF, PH_ID_ACK, PH_DATA_ACK: begin
          if (cmd_i.rx_byte == BYTE_ACK) begin
            if (phase_q == PH_UNCONF) begin
              flags_abs[FlAck] = 1'b1;
            end else if (phase_q == PH_ID_ACK) begin
              phase_abs = PH_ID_0;
            end else begin
              phase_abs = PH_DATA_0;
            end
          end else if (cmd_i.rx_byte == BYTE_RESEND) begin
            flags_abs[FlResend] = 1'b1;
          end else begin
            unexp = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // a (re)send restarts the phase and clears the flags
  always_comb begin
    phase_d = phase_abs;
    flags_d = flags_abs;
    if (cmd_i.launch) begin
      flags_d = '0;
      unique case (cmd_i.kind)
        KIND_DATA:  phase_d = PH_DATA_ACK;
        KIND_IDENT: phase_d = PH_ID_ACK;
        default:    phase_d = PH_UNCONF;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_UNCONF;
      flags_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign view_o = '{phase: phase_abs, flags: flags_abs, first: first_d,
                    second: second_d, unexpected: unexp};

endmodule

// File: rtl/core/ps2dp_ctrl.sv
module ps2dp_ctrl #(
  parameter int unsigned PORT_COUNT = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2dp_pkg::cfg_wr_t    cfg_i,
  input  logic                  fire_i,
  input  ps2dp_pkg::in_item_t   item_i,
  input  ps2dp_pkg::port_view_t views_i [ps2dp_pkg::MaxPorts],
  output ps2dp_pkg::port_cmd_t  cmds_o  [ps2dp_pkg::MaxPorts],
  output ps2dp_pkg::out_item_t  res_o
);
  import ps2dp_pkg::*;

  localparam logic [1:0] PortCnt = 2'(PORT_COUNT);

  logic [15:0] timeout_q;
  logic [3:0]  retries_q;
  logic        busy_q, busy_d;
  logic        aport_q, aport_d;
  logic [1:0]  akind_q, akind_d;
  logic [7:0]  acmd_q, acmd_d;
  logic [3:0]  attempt_q, attempt_d;
  logic [15:0] timer_q, timer_d;

  logic        port_ok;
  logic [15:0] timer_inc;
  port_view_t  av;

  logic        do_finish, do_retry, do_launch, is_ident;
  logic [1:0]  fin_status, id_cnt;
  logic [7:0]  fin_b1;
  logic [7:0]  id_b1, id_b2;
  logic        id_cls, id_guess;
  logic        l_port;
  logic [1:0]  l_kind;
  logic [7:0]  l_byte;

  assign port_ok   = {1'b0, item_i.port} < PortCnt;
  assign timer_inc = (timer_q == 16'hffff) ? timer_q : timer_q + 16'd1;
  assign av        = views_i[aport_q];

  // decision for the current word
  always_comb begin
    busy_d     = busy_q;
    aport_d    = aport_q;
    akind_d    = akind_q;
    acmd_d     = acmd_q;
    attempt_d  = attempt_q;
    timer_d    = timer_q;
    do_finish  = 1'b0;
    do_retry   = 1'b0;
    do_launch  = 1'b0;
    is_ident   = 1'b0;
    fin_status = ST_OK;
    fin_b1     = '0;
    id_cnt     = '0;
    l_port     = aport_q;
    l_kind     = akind_q;
    l_byte     = acmd_q;
    if (fire_i) begin
      unique case (item_i.mode)
        MODE_START: begin
          if (!busy_q && item_i.kind != KIND_NONE && port_ok) begin
            busy_d    = 1'b1;
            aport_d   = item_i.port;
            akind_d   = item_i.kind;
            acmd_d    = item_i.value;
            attempt_d = '0;
            do_launch = 1'b1;
            l_port    = item_i.port;
            l_kind    = item_i.kind;
            l_byte    = item_i.value;
          end
        end
        MODE_BYTE: begin
          if (port_ok && busy_q && item_i.port == aport_q) begin
            timer_d = '0;
            if (akind_q == KIND_SIMPLE) begin
              if (av.flags[FlAck]) begin
                do_finish = 1'b1;
              end else if (av.flags[FlResend]) begin
                do_retry = 1'b1;
              end
            end else if (av.phase == PH_UNCONF) begin
              do_finish = 1'b1;
              if (akind_q == KIND_IDENT) begin
                is_ident = 1'b1;
                id_cnt   = 2'd2;
              end else begin
                fin_b1 = av.first;
              end
            end else if (av.flags[FlResend]) begin
              do_retry = 1'b1;
            end
          end
        end
        MODE_TICK: begin
          if (busy_q) begin
            timer_d = timer_inc;
            if (timer_inc >= timeout_q) begin
              if (akind_q == KIND_SIMPLE) begin
                do_finish  = 1'b1;
                fin_status = ST_TIMEOUT;
              end else if (av.flags[FlResend]) begin
                do_retry = 1'b1;
              end else if (akind_q == KIND_IDENT && av.phase == PH_ID_0) begin
                do_finish = 1'b1;
                is_ident  = 1'b1;
                id_cnt    = 2'd0;
              end else if (akind_q == KIND_IDENT && av.phase == PH_ID_1) begin
                do_finish = 1'b1;
                is_ident  = 1'b1;
                id_cnt    = 2'd1;
              end else begin
                do_finish  = 1'b1;
                fin_status = ST_TIMEOUT;
              end
            end
          end
        end
        default: ;
      endcase
      if (do_retry) begin
        if (attempt_q >= retries_q) begin
          do_finish  = 1'b1;
          fin_status = ST_RETRIES;
        end else begin
          attempt_d = attempt_q + 4'd1;
          do_launch = 1'b1;
        end
      end
      if (do_finish) begin
        busy_d = 1'b0;
      end
      if (do_launch) begin
        timer_d = '0;
      end
    end
  end

  // identify classification
  always_comb begin
    id_b1    = (id_cnt != 2'd0) ? av.first : 8'h00;
    id_b2    = (id_cnt == 2'd2) ? av.second : 8'h00;
    id_cls   = 1'b0;
    id_guess = 1'b0;
    if (id_cnt == 2'd0 || (id_cnt == 2'd2 && id_b1 == ID_KBD_LEAD)) begin
      id_cls = 1'b0;
    end else if (id_cnt == 2'd1 && id_b1 == ID_MOUSE) begin
      id_cls = 1'b1;
    end else begin
      id_cls   = aport_q;
      id_guess = 1'b1;
    end
  end

  always_comb begin
    for (int p = 0; p < MaxPorts; p++) begin
      cmds_o[p].absorb  = fire_i && item_i.mode == MODE_BYTE && port_ok
                          && item_i.port == 1'(p);
      cmds_o[p].launch  = do_launch && l_port == 1'(p);
      cmds_o[p].kind    = l_kind;
      cmds_o[p].rx_byte = item_i.value;
    end
  end

  always_comb begin
    res_o = '0;
    if (fire_i && item_i.mode == MODE_BYTE && port_ok) begin
      res_o.unexpected_byte = views_i[item_i.port].unexpected;
    end
    if (do_launch) begin
      res_o.send_valid = 1'b1;
      res_o.send_port  = l_port;
      res_o.send_byte  = l_byte;
    end
    if (do_finish) begin
      res_o.done_res    = 1'b1;
      res_o.done_status = fin_status;
      if (is_ident) begin
        res_o.id_count      = id_cnt;
        res_o.first_byte    = id_b1;
        res_o.second_byte   = id_b2;
        res_o.device_class  = id_cls;
        res_o.class_guessed = id_guess;
      end else begin
        res_o.first_byte = fin_b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      retries_q <= RETRIES_RESET;
      busy_q    <= 1'b0;
      aport_q   <= 1'b0;
      akind_q   <= KIND_SIMPLE;
      acmd_q    <= '0;
      attempt_q <= '0;
      timer_q   <= '0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          CFG_TIMEOUT: timeout_q <= cfg_i.data;
          CFG_RETRIES: retries_q <= cfg_i.data[3:0];
          default: ;
        endcase
      end
      busy_q    <= busy_d;
      aport_q   <= aport_d;
      akind_q   <= akind_d;
      acmd_q    <= acmd_d;
      attempt_q <= attempt_d;
      timer_q   <= timer_d;
    end
  end

  a_send_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> !(res_o.send_valid && res_o.done_res))
    else $error("send and completion in one word");

  a_start_busy_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && busy_q && item_i.mode == MODE_START) |-> !res_o.send_valid)
    else $error("start accepted while busy");

  a_done_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.done_res) |=> !busy_q)
    else $error("busy still set after completion");

  a_send_restarts_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.send_valid) |=> (timer_q == 16'd0 && busy_q))
    else $error("timer not restarted on send");

  a_unexp_only_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.unexpected_byte) |-> item_i.mode == MODE_BYTE)
    else $error("unexpected flag outside a received byte");

endmodule

// File: tb/sv/ps2dp_tb_pkg.sv
`timescale 1ns / 1ps

package ps2dp_tb_pkg;
  import ps2dp_pkg::*;

  // mirror of the probe engine: one expected result word per accepted input word
  class probe_scoreboard;
    logic [15:0] timeout_ticks;
    logic [3:0]  retry_limit;
    phase_e      phase [2];
    logic [1:0]  flags [2];
    logic [7:0]  cap_first [2];
    logic [7:0]  cap_second [2];
    bit          busy;
    bit          act_port;
    kind_e       act_kind;
    logic [7:0]  act_cmd;
    logic [3:0]  attempts;
    logic [15:0] wait_timer;
    out_item_t   expected_q [$];
    int          errors;

    function new();
      timeout_ticks = TIMEOUT_RESET;
      retry_limit   = RETRIES_RESET;
      for (int p = 0; p < 2; p++) begin
        phase[p]      = PH_UNCONF;
        flags[p]      = '0;
        cap_first[p]  = '0;
        cap_second[p] = '0;
      end
      busy       = 1'b0;
      act_port   = 1'b0;
      act_kind   = KIND_SIMPLE;
      act_cmd    = '0;
      attempts   = '0;
      wait_timer = '0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      if (idx == CFG_TIMEOUT) begin
        timeout_ticks = val;
      end else begin
        retry_limit = val[3:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void launch(inout out_item_t r);
      flags[act_port] = '0;
      case (act_kind)
        KIND_DATA:  phase[act_port] = PH_DATA_ACK;
        KIND_IDENT: phase[act_port] = PH_ID_ACK;
        default:    phase[act_port] = PH_UNCONF;
      endcase
      wait_timer   = '0;
      r.send_valid = 1'b1;
      r.send_port  = act_port;
      r.send_byte  = act_cmd;
    endfunction

    function void complete(inout out_item_t r, input status_e st, input logic [1:0] n,
                           input logic [7:0] b1, input logic [7:0] b2,
                           input bit cls, input bit guess);
      busy            = 1'b0;
      r.done_res      = 1'b1;
      r.done_status   = st;
      r.id_count      = n;
      r.first_byte    = b1;
      r.second_byte   = b2;
      r.device_class  = cls;
      r.class_guessed = guess;
    endfunction

    function void retry(inout out_item_t r);
      if (attempts >= retry_limit) begin
        complete(r, ST_RETRIES, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
      end else begin
        attempts = attempts + 4'd1;
        launch(r);
      end
    endfunction

    function void ident_done(inout out_item_t r, input int n);
      logic [7:0] b1;
      logic [7:0] b2;
      b1 = (n >= 1) ? cap_first[act_port] : 8'h00;
      b2 = (n >= 2) ? cap_second[act_port] : 8'h00;
      if (n == 0 || (n == 2 && b1 == ID_KBD_LEAD)) begin
        complete(r, ST_OK, 2'(n), b1, b2, 1'b0, 1'b0);
      end else if (n == 1 && b1 == ID_MOUSE) begin
        complete(r, ST_OK, 2'(n), b1, b2, 1'b1, 1'b0);
      end else begin
        // unknown id, class falls back to the port
        complete(r, ST_OK, 2'(n), b1, b2, act_port, 1'b1);
      end
    endfunction

    // applies a received word to a port's phase, returns the unexpected flag
    function bit absorb(bit p, logic [7:0] b);
      case (phase[p])
        PH_ID_0: begin
          cap_first[p] = b;
          phase[p]     = PH_ID_1;
        end
        PH_ID_1: begin
          cap_second[p] = b;
          phase[p]      = PH_UNCONF;
        end
        PH_DATA_0: begin
          cap_first[p] = b;
          phase[p]     = PH_UNCONF;
        end
        PH_UNCONF, PH_ID_ACK, PH_DATA_ACK: begin
          if (b == BYTE_ACK) begin
            if (phase[p] == PH_UNCONF) begin
              flags[p][FlAck] = 1'b1;
            end else if (phase[p] == PH_ID_ACK) begin
              phase[p] = PH_ID_0;
            end else begin
              phase[p] = PH_DATA_0;
            end
          end else if (b == BYTE_RESEND) begin
            flags[p][FlResend] = 1'b1;
          end else begin
            return 1'b1;
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void note_word(in_item_t w);
      out_item_t r;
      bit        ap;
      r  = '0;
      ap = act_port;
      case (w.mode)
        MODE_START: begin
          if (!busy && w.kind != KIND_NONE) begin
            busy     = 1'b1;
            act_port = w.port;
            act_kind = kind_e'(w.kind);
            act_cmd  = w.value;
            attempts = '0;
            launch(r);
          end
        end
        MODE_BYTE: begin
          r.unexpected_byte = absorb(w.port, w.value);
          if (busy && w.port == ap) begin
            wait_timer = '0;
            if (act_kind == KIND_SIMPLE) begin
              if (flags[ap][FlAck]) begin
                complete(r, ST_OK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
              end else if (flags[ap][FlResend]) begin
                retry(r);
              end
            end else if (phase[ap] == PH_UNCONF) begin
              if (act_kind == KIND_IDENT) begin
                ident_done(r, 2);
              end else begin
                complete(r, ST_OK, 2'd0, cap_first[ap], 8'h00, 1'b0, 1'b0);
              end
            end else if (flags[ap][FlResend]) begin
              retry(r);
            end
          end
        end
        MODE_TICK: begin
          if (busy) begin
            if (wait_timer != 16'hffff) wait_timer = wait_timer + 16'd1;
            if (wait_timer >= timeout_ticks) begin
              if (act_kind == KIND_SIMPLE) begin
                complete(r, ST_TIMEOUT, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
              end else if (flags[ap][FlResend]) begin
                retry(r);
              end else if (act_kind == KIND_IDENT && phase[ap] == PH_ID_0) begin
                ident_done(r, 0);
              end else if (act_kind == KIND_IDENT && phase[ap] == PH_ID_1) begin
                ident_done(r, 1);
              end else begin
                complete(r, ST_TIMEOUT, 2'd0, 8'h00, 8'h00, 1'b0, 1'b0);
              end
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function string show(out_item_t o);
      return $sformatf({"send %0b p%0d %02h done %0b st %0d n %0d b %02h %02h ",
                        "cls %0b guess %0b unexp %0b"},
                       o.send_valid, o.send_port, o.send_byte, o.done_res, o.done_status,
                       o.id_count, o.first_byte, o.second_byte, o.device_class,
                       o.class_guessed, o.unexpected_byte);
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        if (errors < 10) $display("result word with nothing expected: %s", show(got));
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        if (errors < 10) $display("mismatch: expected %s / got %s", show(want), show(got));
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/tb_ps2_device_probe_engine.sv
`timescale 1ns / 1ps

module tb_ps2_device_probe_engine;
  import ps2dp_pkg::*;
  import ps2dp_tb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 6;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_TIMEOUT;
  logic [15:0] cfg_data_i  = '0;

  // no random idling on either side while set
  bit calm = 1'b0;

  // register settings and word counts for each random phase
  int unsigned phase_tmo [NumPhases] = '{1, 0, 3, 65535, 2, 5};
  int unsigned phase_rty [NumPhases] = '{0, 15, 2, 15, 1, 4};
  int unsigned phase_len [NumPhases] = '{150, 110, 200, 60, 170, 160};

  probe_scoreboard sb = new();

  ps2_device_probe_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i = calm || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic in_item_t word_of(mode_e m, bit p, kind_e k, logic [7:0] v);
    in_item_t w;
    w.mode  = m;
    w.port  = p;
    w.kind  = k;
    w.value = v;
    return w;
  endfunction

  // reply bytes weighted towards what the port is waiting for
  function automatic logic [7:0] reply_byte(phase_e ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (ph inside {PH_ID_0, PH_ID_1, PH_DATA_0}) begin
      if (r < 30) return ID_KBD_LEAD;
      if (r < 55) return ID_MOUSE;
      if (r < 65) return BYTE_ACK;
      if (r < 70) return BYTE_RESEND;
    end else begin
      if (r < 60) return BYTE_ACK;
      if (r < 85) return BYTE_RESEND;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t pick_word();
    in_item_t    w;
    int unsigned r;
    bit          ap;
    w.mode  = MODE_BYTE;
    w.port  = 1'($urandom_range(0, 1));
    w.kind  = 2'($urandom_range(0, 3));
    w.value = 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    ap = sb.act_port;
    if (!sb.busy) begin
      if (r < 3) begin
        w.mode = MODE_START;
        w.kind = KIND_NONE;
      end else if (r < 70) begin
        w.mode = MODE_START;
        w.kind = 2'($urandom_range(0, 2));
      end else if (r < 78) begin
        w.mode = MODE_TICK;
      end else if (r < 83) begin
        w.mode = MODE_NONE;
      end else begin
        w.value = reply_byte(sb.phase[w.port]);
      end
    end else if (r < 3) begin
      w.mode = MODE_START;
    end else if (r < 5) begin
      w.mode = MODE_NONE;
    end else if (r < 9) begin
      w.port  = ap ^ 1'b1;
      w.value = reply_byte(sb.phase[w.port]);
    end else if (r < 34) begin
      w.mode = MODE_TICK;
    end else begin
      w.port  = ap;
      w.value = reply_byte(sb.phase[ap]);
    end
    return w;
  endfunction

  // byte from the active port that moves the running command towards its end
  function automatic in_item_t closing_word();
    bit ap;
    ap = sb.act_port;
    if (sb.phase[ap] inside {PH_ID_0, PH_ID_1, PH_DATA_0}) begin
      return word_of(MODE_BYTE, ap, KIND_SIMPLE, 8'($urandom_range(0, 255)));
    end
    return word_of(MODE_BYTE, ap, KIND_SIMPLE, BYTE_ACK);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input in_item_t w);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    while (sb.busy) send_word(closing_word());
    wait_results();
  endtask

  task automatic write_regs(input logic [15:0] tmo, input logic [3:0] rty);
    cfg_idx_e    idx;
    logic [15:0] val;
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? CFG_TIMEOUT : CFG_RETRIES;
      // upper bits of the retry word are don't-care
      val = (i == 0) ? tmo : {12'($urandom_range(0, 4095)), rty};
      cfg_valid_i = 1'b1;
      cfg_index_i = idx;
      cfg_data_i  = val;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx, val);
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 3) wait_results();
      send_word(pick_word());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: ignored words, resend and retry, unexpected bytes
    send_word(word_of(MODE_TICK, 1'b0, KIND_SIMPLE, 8'h00));
    send_word(word_of(MODE_NONE, 1'b1, KIND_NONE, 8'hff));
    send_word(word_of(MODE_START, 1'b0, KIND_NONE, 8'hf4));
    send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, BYTE_ACK));
    send_word(word_of(MODE_START, 1'b0, KIND_SIMPLE, 8'hff));
    send_word(word_of(MODE_START, 1'b1, KIND_IDENT, 8'hf2));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, BYTE_RESEND));
    send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, 8'h55));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, BYTE_ACK));
    // two id bytes not known: class guessed
    send_word(word_of(MODE_START, 1'b1, KIND_IDENT, 8'hf2));
    send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, BYTE_ACK));
    send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, 8'h12));
    send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, 8'h34));
    send_word(word_of(MODE_START, 1'b0, KIND_DATA, 8'h00));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, BYTE_ACK));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, 8'hff));
    // keyboard id
    send_word(word_of(MODE_START, 1'b0, KIND_IDENT, 8'hf2));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, BYTE_ACK));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, ID_KBD_LEAD));
    send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, 8'h83));
    // resends until the retry budget runs out
    send_word(word_of(MODE_START, 1'b1, KIND_SIMPLE, 8'hed));
    for (int i = 0; i < 4; i++) send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, BYTE_RESEND));
    settle();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      write_regs(16'(phase_tmo[ph]), 4'(phase_rty[ph]));
      if (ph == 0) begin
        // identify ending on timeout with no id byte, then with a mouse id byte
        send_word(word_of(MODE_START, 1'b0, KIND_IDENT, 8'hf2));
        send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, BYTE_ACK));
        send_word(word_of(MODE_TICK, 1'b0, KIND_SIMPLE, 8'h00));
        send_word(word_of(MODE_START, 1'b1, KIND_IDENT, 8'hf2));
        send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, BYTE_ACK));
        send_word(word_of(MODE_BYTE, 1'b1, KIND_SIMPLE, ID_MOUSE));
        send_word(word_of(MODE_TICK, 1'b1, KIND_SIMPLE, 8'h00));
        send_word(word_of(MODE_START, 1'b1, KIND_DATA, 8'he8));
        send_word(word_of(MODE_TICK, 1'b0, KIND_SIMPLE, 8'h00));
        // no retries allowed: first resend gives up
        send_word(word_of(MODE_START, 1'b0, KIND_SIMPLE, 8'hed));
        send_word(word_of(MODE_BYTE, 1'b0, KIND_SIMPLE, BYTE_RESEND));
      end
      calm = (ph == 2);
      run_random(phase_len[ph]);
      calm = 1'b0;
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
